>>> rtl/nlp_pkg.sv
`default_nettype none

package nlp_pkg;

    // sequence capacity and derived widths
    localparam int MAX_LEN = 16;
    localparam int ELEM_W  = 8;
    localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int ADDR_W  = IDX_W + 1;

    typedef logic [ELEM_W-1:0] t_elem;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [ADDR_W-1:0] t_addr;

    // operation codes carried in s_axis_tuser
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

endpackage

`default_nettype wire

>>> rtl/next_lex_permutation.sv
`default_nettype none

// Channel   Dir  tdata          tuser        tlast
// s_axis    in   element_in     operation    load_last
// m_axis    out  element_out    exhausted    run_last
//
// An advance scans for the pivot, then for its swap partner, then emits the
// result. The single read port of the two-bank element memory means each
// step reads one element.
// Synchronous active-low reset clears length, bank select and handshake state;
// the element memory is not cleared. Output stalls hold the emission pipeline.

module next_lex_permutation (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire  [7:0] s_axis_tdata,   // [7:0] element_in
    input  wire        s_axis_tuser,   // [0] operation
    input  wire        s_axis_tlast,   // load_last
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] element_out
    output logic       m_axis_tuser,   // [0] exhausted
    output logic       m_axis_tlast    // run_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PSCAN,
        S_HSCAN,
        S_EMIT,
        S_EXH
    } t_state;

    localparam int SUM_W = nlp_pkg::LEN_W + 1;
    typedef logic [SUM_W-1:0] t_sum;

    // element memory: two banks, the active one holds the sequence
    nlp_pkg::t_elem r_mem [2*nlp_pkg::MAX_LEN];
    nlp_pkg::t_elem r_rdata;

    t_state         r_state, n_state;
    nlp_pkg::t_len  r_len, n_len;
    logic           r_closed, n_closed;
    logic           r_bank, n_bank;
    logic           r_first, n_first;
    nlp_pkg::t_idx  r_addr, n_addr;
    nlp_pkg::t_elem r_right, n_right;
    nlp_pkg::t_idx  r_piv, n_piv;
    nlp_pkg::t_elem r_pv, n_pv;
    nlp_pkg::t_idx  r_hi, n_hi;
    nlp_pkg::t_elem r_hv, n_hv;
    nlp_pkg::t_len  r_ek, n_ek;
    logic           r_pend, n_pend;
    nlp_pkg::t_idx  r_pk, n_pk;
    logic           r_psub_hv, n_psub_hv;
    logic           r_psub_pv, n_psub_pv;
    logic           r_plast, n_plast;
    logic           r_ov, n_ov;
    nlp_pkg::t_elem r_od, n_od;
    logic           r_olast, n_olast;
    logic           r_oexh, n_oexh;

    logic           rd_en;
    nlp_pkg::t_idx  rd_idx;
    logic           wr_en;
    nlp_pkg::t_addr wr_addr;
    nlp_pkg::t_elem wr_data;

    logic           in_req;
    logic           out_free;
    logic           move;
    nlp_pkg::t_len  load_base;
    nlp_pkg::t_len  piv_len;
    t_sum           src_sum;
    nlp_pkg::t_idx  src_idx;
    nlp_pkg::t_elem move_val;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_req        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ov || m_axis_tready;
    assign move          = r_pend && out_free;
    assign load_base     = r_closed ? '0 : r_len;
    assign piv_len       = nlp_pkg::t_len'(r_piv);

    // source of result k: pivot+n-k inside the reversed suffix
    assign src_sum  = t_sum'(r_piv) + t_sum'(r_len) - t_sum'(r_ek);
    assign src_idx  = (r_ek > piv_len) ? src_sum[nlp_pkg::IDX_W-1:0]
                                       : r_ek[nlp_pkg::IDX_W-1:0];
    assign move_val = r_psub_hv ? r_hv : (r_psub_pv ? r_pv : r_rdata);

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_oexh;

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_closed  = r_closed;
        n_bank    = r_bank;
        n_first   = r_first;
        n_addr    = r_addr;
        n_right   = r_right;
        n_piv     = r_piv;
        n_pv      = r_pv;
        n_hi      = r_hi;
        n_hv      = r_hv;
        n_ek      = r_ek;
        n_pend    = r_pend;
        n_pk      = r_pk;
        n_psub_hv = r_psub_hv;
        n_psub_pv = r_psub_pv;
        n_plast   = r_plast;
        n_ov      = r_ov && !m_axis_tready;
        n_od      = r_od;
        n_olast   = r_olast;
        n_oexh    = r_oexh;
        rd_en     = 1'b0;
        rd_idx    = r_addr;
        wr_en     = 1'b0;
        wr_addr   = {r_bank, load_base[nlp_pkg::IDX_W-1:0]};
        wr_data   = s_axis_tdata;

        unique case (r_state)
            S_IDLE: begin
                if (in_req && s_axis_tuser == nlp_pkg::OP_LOAD) begin
                    // append one element, drop beyond capacity
                    n_closed = s_axis_tlast;
                    if (load_base < nlp_pkg::t_len'(nlp_pkg::MAX_LEN)) begin
                        wr_en = 1'b1;
                        n_len = load_base + 1'b1;
                    end else begin
                        n_len = load_base;
                    end
                end else if (in_req) begin
                    if (r_len < nlp_pkg::t_len'(2)) begin
                        n_state = S_EXH;
                    end else begin
                        // read the last element to open the pivot scan
                        rd_en   = 1'b1;
                        rd_idx  = nlp_pkg::t_idx'(r_len - 1'b1);
                        n_addr  = rd_idx;
                        n_first = 1'b1;
                        n_state = S_PSCAN;
                    end
                end
            end
            S_PSCAN: begin
                // r_rdata holds element r_addr, r_right element r_addr+1
                n_first = 1'b0;
                if (!r_first && r_rdata < r_right) begin
                    n_piv   = r_addr;
                    n_pv    = r_rdata;
                    rd_en   = 1'b1;
                    rd_idx  = nlp_pkg::t_idx'(r_len - 1'b1);
                    n_addr  = rd_idx;
                    n_state = S_HSCAN;
                end else if (r_addr == '0) begin
                    n_state = S_EXH;
                end else begin
                    n_right = r_rdata;
                    rd_en   = 1'b1;
                    rd_idx  = r_addr - 1'b1;
                    n_addr  = rd_idx;
                end
            end
            S_HSCAN: begin
                // rightmost element above the pivot value
                if (r_rdata > r_pv) begin
                    n_hi    = r_addr;
                    n_hv    = r_rdata;
                    n_ek    = '0;
                    n_pend  = 1'b0;
                    n_state = S_EMIT;
                end else begin
                    rd_en  = 1'b1;
                    rd_idx = r_addr - 1'b1;
                    n_addr = rd_idx;
                end
            end
            S_EMIT: begin
                // stage two: result to output and into the other bank
                if (move) begin
                    wr_en   = 1'b1;
                    wr_addr = {~r_bank, r_pk};
                    wr_data = move_val;
                    n_ov    = 1'b1;
                    n_od    = move_val;
                    n_olast = r_plast;
                    n_oexh  = 1'b0;
                    n_pend  = 1'b0;
                    if (r_plast) begin
                        n_bank  = ~r_bank;
                        n_state = S_IDLE;
                    end
                end
                // stage one: read the source of the next result
                if (r_ek < r_len && (!r_pend || move)) begin
                    rd_en     = 1'b1;
                    rd_idx    = src_idx;
                    n_pend    = 1'b1;
                    n_pk      = r_ek[nlp_pkg::IDX_W-1:0];
                    n_psub_hv = (r_ek == piv_len);
                    n_psub_pv = (r_ek > piv_len) && (src_idx == r_hi);
                    n_plast   = (r_ek + 1'b1 == r_len);
                    n_ek      = r_ek + 1'b1;
                end
            end
            S_EXH: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_od    = '0;
                    n_olast = 1'b1;
                    n_oexh  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_closed <= 1'b1;
            r_bank   <= 1'b0;
            r_pend   <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_closed <= n_closed;
            r_bank   <= n_bank;
            r_pend   <= n_pend;
            r_ov     <= n_ov;
        end
        r_first   <= n_first;
        r_addr    <= n_addr;
        r_right   <= n_right;
        r_piv     <= n_piv;
        r_pv      <= n_pv;
        r_hi      <= n_hi;
        r_hv      <= n_hv;
        r_ek      <= n_ek;
        r_pk      <= n_pk;
        r_psub_hv <= n_psub_hv;
        r_psub_pv <= n_psub_pv;
        r_plast   <= n_plast;
        r_od      <= n_od;
        r_olast   <= n_olast;
        r_oexh    <= n_oexh;
    end

    // element memory, read data held while no read is issued
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[{r_bank, rd_idx}];
        end
    end

endmodule

`default_nettype wire

>>> tb/tb_next_lex_permutation.sv
module tb_next_lex_permutation;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQS = 384;
    localparam int PHASES      = 4;
    localparam int DRAIN_WAIT  = 3 * nlp_pkg::MAX_LEN + 40;

    // one emitted element of a permutation run
    typedef struct packed {
        nlp_pkg::t_elem elem;
        logic           last;
        logic           exh;
    } t_perm_beat;

    // directed stimulus row; exh_typed marks a row whose result is a known exhausted beat
    typedef struct packed {
        logic           op;
        nlp_pkg::t_elem elem;
        logic           last;
        logic           exh_typed;
    } t_stim_row;

    localparam int DIR_ROWS = 23;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;     // [7:0] element_in
    logic       s_axis_tuser = 1'b0;   // [0] operation
    logic       s_axis_tlast = 1'b0;   // load_last
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;          // [7:0] element_out
    logic       m_axis_tuser;          // [0] exhausted
    logic       m_axis_tlast;          // run_last

    // shadow copy of the block state
    nlp_pkg::t_elem shadow_store [nlp_pkg::MAX_LEN];
    int unsigned    shadow_len;
    bit             shadow_closed;

    t_perm_beat  perm_beats_due [$];

    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;
    int unsigned reqs_sent;
    int unsigned mismatch_count;
    int unsigned fail_count;

    t_stim_row directed_rows [DIR_ROWS] = '{
        '{nlp_pkg::OP_ADVANCE, 8'h00, 1'b0, 1'b1},  // advance right after reset: empty
        '{nlp_pkg::OP_LOAD,    8'h00, 1'b1, 1'b0},
        '{nlp_pkg::OP_ADVANCE, 8'h00, 1'b0, 1'b1},  // single element: no ascent
        '{nlp_pkg::OP_LOAD,    8'h00, 1'b0, 1'b0},
        '{nlp_pkg::OP_LOAD,    8'hFF, 1'b0, 1'b0},
        '{nlp_pkg::OP_LOAD,    8'h80, 1'b1, 1'b0},
        '{nlp_pkg::OP_ADVANCE, 8'hFF, 1'b1, 1'b0},  // element and last ignored on advance
        '{nlp_pkg::OP_LOAD,    8'h01, 1'b0, 1'b0},
        '{nlp_pkg::OP_LOAD,    8'h01, 1'b0, 1'b0},
        '{nlp_pkg::OP_LOAD,    8'h02, 1'b1, 1'b0},
        '{nlp_pkg::OP_ADVANCE, 8'h00, 1'b0, 1'b0},  // repeated values
        '{nlp_pkg::OP_ADVANCE, 8'hAA, 1'b0, 1'b0},
        '{nlp_pkg::OP_ADVANCE, 8'h00, 1'b0, 1'b1},  // last permutation reached
        '{nlp_pkg::OP_ADVANCE, 8'h00, 1'b0, 1'b1},  // state left unchanged
        '{nlp_pkg::OP_LOAD,    8'h55, 1'b0, 1'b0},
        '{nlp_pkg::OP_LOAD,    8'hAA, 1'b0, 1'b0},
        '{nlp_pkg::OP_ADVANCE, 8'h00, 1'b0, 1'b0},  // advance while load still open
        '{nlp_pkg::OP_LOAD,    8'h01, 1'b1, 1'b0},  // keeps appending
        '{nlp_pkg::OP_ADVANCE, 8'h00, 1'b0, 1'b1},
        '{nlp_pkg::OP_LOAD,    8'h7F, 1'b0, 1'b0},
        '{nlp_pkg::OP_LOAD,    8'hFE, 1'b1, 1'b0},
        '{nlp_pkg::OP_ADVANCE, 8'h00, 1'b0, 1'b0},
        '{nlp_pkg::OP_ADVANCE, 8'h00, 1'b0, 1'b1}
    };

    next_lex_permutation u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // append one beat to the expected queue
    function automatic void enqueue_beat(input t_perm_beat beat);
        perm_beats_due = {perm_beats_due, beat};
    endfunction

    // next permutation of the shadow store in place; 0 when there is no ascent
    function automatic bit advance_shadow();
        int             pos;
        int             pivot;
        int             lo;
        int             hi;
        nlp_pkg::t_elem tmp;
        if (shadow_len < 2) return 1'b0;
        pos = shadow_len - 1;
        while (pos > 0 && shadow_store[pos-1] >= shadow_store[pos]) pos--;
        if (pos == 0) return 1'b0;
        pivot = pos - 1;
        hi = shadow_len - 1;
        while (shadow_store[hi] <= shadow_store[pivot]) hi--;
        tmp = shadow_store[pivot];
        shadow_store[pivot] = shadow_store[hi];
        shadow_store[hi] = tmp;
        lo = pivot + 1;
        hi = shadow_len - 1;
        while (lo < hi) begin
            tmp = shadow_store[lo];
            shadow_store[lo] = shadow_store[hi];
            shadow_store[hi] = tmp;
            lo++;
            hi--;
        end
        return 1'b1;
    endfunction

    // apply one accepted request to the shadow and queue the beats it produces
    task automatic shadow_request(input logic op, input nlp_pkg::t_elem elem,
                                  input logic last, input bit exh_typed);
        t_perm_beat beat;
        beat.elem = 8'h00;
        beat.last = 1'b1;
        beat.exh  = 1'b1;
        if (op == nlp_pkg::OP_LOAD) begin
            if (shadow_closed) begin
                shadow_len = 0;
                shadow_closed = 1'b0;
            end
            if (shadow_len < nlp_pkg::MAX_LEN) begin
                shadow_store[shadow_len] = elem;
                shadow_len++;
            end
            if (last) shadow_closed = 1'b1;
        end else if (exh_typed) begin
            void'(advance_shadow());
            enqueue_beat(beat);
        end else if (!advance_shadow()) begin
            enqueue_beat(beat);
        end else begin
            for (int k = 0; k < shadow_len; k++) begin
                beat.elem = shadow_store[k];
                beat.last = (k == shadow_len - 1);
                beat.exh  = 1'b0;
                enqueue_beat(beat);
            end
        end
    endtask

    // drive one request and hold it until the handshake; tvalid stays up on return
    task automatic send_req(input logic op, input nlp_pkg::t_elem elem, input logic last,
                            input bit exh_typed);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= elem;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        shadow_request(op, elem, last, exh_typed);
        reqs_sent++;
    endtask

    task automatic wait_all_beats();
        s_axis_tvalid <= 1'b0;
        while (perm_beats_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic load_run(input int unsigned len, input bit close, input bit narrow);
        nlp_pkg::t_elem base;
        nlp_pkg::t_elem val;
        base = nlp_pkg::t_elem'($urandom_range(252));
        for (int k = 0; k < len; k++) begin
            val = narrow ? nlp_pkg::t_elem'(base + $urandom_range(3))
                         : nlp_pkg::t_elem'($urandom_range(255));
            send_req(nlp_pkg::OP_LOAD, val, close && (k == len - 1), 1'b0);
        end
    endtask

    task automatic send_advance();
        send_req(nlp_pkg::OP_ADVANCE, nlp_pkg::t_elem'($urandom_range(255)),
                 1'($urandom_range(1)), 1'b0);
    endtask

    // one random scenario: mostly a full load then advances, sometimes noise
    task automatic random_scenario();
        int unsigned kind;
        int unsigned pick;
        int unsigned len;
        int unsigned n_adv;
        bit          narrow;
        kind   = $urandom_range(99);
        narrow = 1'($urandom_range(1));
        if (kind < 80) begin
            pick = $urandom_range(99);
            if (pick < 55)      len = $urandom_range(1, 4);
            else if (pick < 80) len = $urandom_range(5, 9);
            else if (pick < 90) len = $urandom_range(10, nlp_pkg::MAX_LEN - 1);
            else if (pick < 95) len = nlp_pkg::MAX_LEN;
            else                len = $urandom_range(nlp_pkg::MAX_LEN + 1,
                                                     nlp_pkg::MAX_LEN + 4);
            load_run(len, 1'b1, narrow);
            n_adv = (len <= 3) ? $urandom_range(1, 8) : $urandom_range(1, 5);
            repeat (n_adv) send_advance();
        end else if (kind < 90) begin
            // advance in the middle of an open load
            load_run($urandom_range(1, 4), 1'b0, narrow);
            send_advance();
            load_run($urandom_range(1, 3), 1'b1, narrow);
            send_advance();
        end else if (kind < 95) begin
            send_advance();
        end else begin
            load_run($urandom_range(1, 3), 1'($urandom_range(1)), narrow);
        end
    endtask

    // output side backpressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        t_perm_beat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (perm_beats_due.size() == 0) begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: elem=%02h last=%0b exh=%0b",
                             m_axis_tdata, m_axis_tlast, m_axis_tuser);
            end else begin
                want = perm_beats_due.pop_front();
                if (m_axis_tdata !== want.elem || m_axis_tlast !== want.last ||
                    m_axis_tuser !== want.exh) begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp %02h/%0b/%0b got %02h/%0b/%0b",
                                 want.elem, want.last, want.exh,
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
                end
            end
        end
    end

    // stimulus
    initial begin
        shadow_len     = 0;
        shadow_closed  = 1'b1;
        src_idle_pct   = 0;
        snk_stall_pct  = 0;
        reqs_sent      = 0;
        mismatch_count = 0;
        fail_count     = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++)
            send_req(directed_rows[r].op, directed_rows[r].elem, directed_rows[r].last,
                     directed_rows[r].exh_typed);

        reqs_sent = 0;
        for (int ph = 0; ph < PHASES; ph++) begin
            // hold off the sender until the block has drained
            wait_all_beats();
            case (ph)
                0: begin
                    src_idle_pct = 0;  snk_stall_pct = 0;
                end
                1: begin
                    src_idle_pct = 82; snk_stall_pct = 0;
                end
                2: begin
                    src_idle_pct = 0;  snk_stall_pct = 82;
                end
                default: begin
                    src_idle_pct = 7;  snk_stall_pct = 7;
                end
            endcase
            while (reqs_sent < (ph + 1) * RANDOM_REQS / PHASES) random_scenario();
        end

        wait_all_beats();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0 && perm_beats_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            if (perm_beats_due.size() != 0)
                $display("%0d expected results never arrived", perm_beats_due.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // run limit
    initial begin
        #(2_000_000);
        $display("timeout: %0d results still pending", perm_beats_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
rtl/nlp_pkg.sv
rtl/next_lex_permutation.sv
tb/tb_next_lex_permutation.sv
